/* hdl/rkc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkc_pkg: shared types and constants of the RGB 3x3 convolution block
// Register map indexes, reset values, fixed field widths and the sequencer
// state type.
// ----------------------------------------------------------------------------
package rkc_pkg;

  // Kernel geometry
  localparam int KERNEL = 3;
  localparam int KTAPS  = KERNEL * KERNEL;
  localparam int TAP_W  = 4;

  // Pixel layout
  localparam int NCH    = 3;
  localparam int PIX_W  = 8;
  localparam int RGB_W  = NCH * PIX_W;
  localparam int PIX_MAX = 255;

  // Frame geometry
  localparam int ROW_W      = 12;
  localparam int MAX_HEIGHT = 4096;

  // Configuration register widths
  localparam int CFG_COEF_W   = 24;
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 5;
  localparam int REG_IDX_W    = 3;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_COEF_TOP    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_MID    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_BOTTOM = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_IMG_WIDTH   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_IMG_HEIGHT  = 3'd4;

  // Register reset values (middle row holds the identity kernel)
  localparam logic [CFG_COEF_W-1:0]   RST_COEF_TOP    = 24'h000000;
  localparam logic [CFG_COEF_W-1:0]   RST_COEF_MID    = 24'h000100;
  localparam logic [CFG_COEF_W-1:0]   RST_COEF_BOTTOM = 24'h000000;
  localparam logic [CFG_WIDTH_W-1:0]  RST_IMG_WIDTH   = 11'd512;
  localparam logic [CFG_HEIGHT_W-1:0] RST_IMG_HEIGHT  = 13'd512;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } st_e;

endpackage

/* hdl/rgb_kernel_convolution_3x3.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_kernel_convolution_3x3: normalized 3x3 convolution of an RGB stream
// Raster pixels in, one filtered and clamped pixel out per interior pixel.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one transaction per pixel, and each interior
// pixel yields one result transaction; border pixels yield none, and tlast
// marks the last interior pixel of a frame. A single line memory of
// MAX_WIDTH words holds the two previous lines side by side; it is read when
// a pixel is taken and written back in the next cycle with the lines
// shifted up. A border pixel passes through the read state back to idle.
// For an interior pixel, one multiply-accumulate unit per channel walks the
// nine taps one per cycle, then a restoring divider per channel produces one
// quotient bit per cycle over COEF_BITS + 13 bits. The result waits in an
// output register, so the next pixel may be taken while it is not yet
// consumed. The line memory is not cleared after reset; the first two lines
// of a frame fill it before any entry is used. Configuration registers sit
// at byte addresses 0, 4, 8, 12 and 16; the user must see that they are
// written only while the block is idle, as the block does not enforce it.
module rgb_kernel_convolution_3x3
  import rkc_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int COEF_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // Pixel input
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [RGB_W-1:0]      s_axis_tdata,  // pix_red, pix_green, pix_blue
  // Filtered output
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [RGB_W-1:0]      m_axis_tdata,  // out_red, out_green, out_blue
  output logic                  m_axis_tlast   // frame_end
);

  // Derived widths
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WCMP_W  = (COL_W + 1 > CFG_WIDTH_W) ? COL_W + 1 : CFG_WIDTH_W;
  localparam int CROW_W  = KERNEL * COEF_BITS;
  localparam int PROD_W  = COEF_BITS + PIX_W + 1;
  localparam int ACC_W   = COEF_BITS + 13;
  localparam int NORM_W  = COEF_BITS + 4;
  localparam int DCNT_W  = $clog2(ACC_W);
  localparam int LINE_W  = 2 * RGB_W;

  // Configuration registers
  logic [CFG_COEF_W-1:0]   coef_top_q, coef_mid_q, coef_bot_q;
  logic [CFG_WIDTH_W-1:0]  img_width_q;
  logic [CFG_HEIGHT_W-1:0] img_height_q;
  logic                    cfg_wr;
  logic [REG_IDX_W-1:0]    reg_idx;

  // Sequencer
  st_e                     state_q, state_d;
  logic                    in_acc;
  logic                    out_load;

  // Stream position
  logic [COL_W-1:0]        col_q;
  logic [ROW_W-1:0]        row_q;
  logic [COL_W-1:0]        width_last;
  logic [ROW_W-1:0]        height_last;
  logic [WCMP_W-1:0]       width_ext;
  logic                    last_col, last_row, produce;
  logic                    fe_q;

  // Line memory and window
  logic [LINE_W-1:0]       line_mem [MAX_WIDTH];
  logic [LINE_W-1:0]       rd_data_q;
  logic [RGB_W-1:0]        pix_q;
  logic [RGB_W-1:0]        win_q [KTAPS];

  // Multiply-accumulate
  logic [CFG_COEF_W-1:0]   coef_rows [KERNEL];
  logic [CROW_W+CFG_COEF_W-1:0] row_ext;
  logic signed [COEF_BITS-1:0]  coef_tap [KTAPS];
  logic signed [COEF_BITS-1:0]  coef_sel;
  logic [RGB_W-1:0]        win_sel;
  logic signed [PROD_W-1:0]     prod [NCH];
  logic [TAP_W-1:0]        tap_q;
  logic signed [ACC_W-1:0]      acc_q [NCH];
  logic signed [NORM_W-1:0]     norm_q;

  // Divider
  logic [ACC_W-1:0]        acc_abs [NCH];
  logic [NORM_W-1:0]       norm_abs;
  logic [NORM_W-1:0]       div_mag_q;
  logic [NORM_W-1:0]       rem_q [NCH];
  logic [ACC_W-1:0]        dq_q [NCH];
  logic [NCH-1:0]          neg_q;
  logic [DCNT_W-1:0]       div_cnt_q;
  logic [NORM_W+1:0]       trial [NCH];
  logic [NORM_W:0]         rem_sh [NCH];
  logic [PIX_W-1:0]        res [NCH];

  // Output register
  logic                    m_valid_q;
  logic [RGB_W-1:0]        m_data_q;
  logic                    m_last_q;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  // Write registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_top_q   <= RST_COEF_TOP;
      coef_mid_q   <= RST_COEF_MID;
      coef_bot_q   <= RST_COEF_BOTTOM;
      img_width_q  <= RST_IMG_WIDTH;
      img_height_q <= RST_IMG_HEIGHT;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_COEF_TOP:    coef_top_q   <= pwdata[CFG_COEF_W-1:0];
        REG_COEF_MID:    coef_mid_q   <= pwdata[CFG_COEF_W-1:0];
        REG_COEF_BOTTOM: coef_bot_q   <= pwdata[CFG_COEF_W-1:0];
        REG_IMG_WIDTH:   img_width_q  <= pwdata[CFG_WIDTH_W-1:0];
        REG_IMG_HEIGHT:  img_height_q <= pwdata[CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back registers
  always_comb begin
    case (reg_idx)
      REG_COEF_TOP:    prdata = APB_DATA_W'(coef_top_q);
      REG_COEF_MID:    prdata = APB_DATA_W'(coef_mid_q);
      REG_COEF_BOTTOM: prdata = APB_DATA_W'(coef_bot_q);
      REG_IMG_WIDTH:   prdata = APB_DATA_W'(img_width_q);
      REG_IMG_HEIGHT:  prdata = APB_DATA_W'(img_height_q);
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Geometry: clamp width to 3..MAX_WIDTH and height to 3..MAX_HEIGHT
  // --------------------------------------------------------------------------
  assign width_ext = WCMP_W'(img_width_q);

  always_comb begin
    if (width_ext < WCMP_W'(3)) begin
      width_last = COL_W'(2);
    end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
      width_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      width_last = COL_W'(width_ext - WCMP_W'(1));
    end
  end

  always_comb begin
    if (img_height_q < CFG_HEIGHT_W'(3)) begin
      height_last = ROW_W'(2);
    end else if (img_height_q > CFG_HEIGHT_W'(MAX_HEIGHT)) begin
      height_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      height_last = ROW_W'(img_height_q - CFG_HEIGHT_W'(1));
    end
  end

  assign last_col = (col_q >= width_last);
  assign last_row = (row_q >= height_last);
  assign produce  = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = produce ? ST_MAC : ST_IDLE;
      end
      ST_MAC: begin
        if (tap_q == TAP_W'(KTAPS - 1)) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt_q == DCNT_W'(ACC_W - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_acc = s_axis_tvalid & s_axis_tready;

  // --------------------------------------------------------------------------
  // Line memory: read at accept, write shifted lines back in the next cycle and not later
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_data_q <= line_mem[col_q];
    end
    if (state_q == ST_READ) begin
      line_mem[col_q] <= {pix_q, rd_data_q[LINE_W-1:RGB_W]};
    end
  end

  // Hold incoming pixel
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_q <= s_axis_tdata;
    end
  end

  // --------------------------------------------------------------------------
  // Window shift and position counters
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KTAPS; i++) begin
        win_q[i] <= '0;
      end
      col_q <= '0;
      row_q <= '0;
      fe_q  <= 1'b0;
    end else if (state_q == ST_READ) begin
      for (int r = 0; r < KERNEL; r++) begin
        win_q[r*KERNEL]     <= win_q[r*KERNEL + 1];
        win_q[r*KERNEL + 1] <= win_q[r*KERNEL + 2];
      end
      win_q[KERNEL - 1]     <= rd_data_q[RGB_W-1:0];
      win_q[2*KERNEL - 1]   <= rd_data_q[LINE_W-1:RGB_W];
      win_q[3*KERNEL - 1]   <= pix_q;
      fe_q                  <= last_col & last_row;
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Kernel taps from the row registers (fields above the register read zero)
  // --------------------------------------------------------------------------
  assign coef_rows[0] = coef_top_q;
  assign coef_rows[1] = coef_mid_q;
  assign coef_rows[2] = coef_bot_q;

  always_comb begin
    row_ext = '0;
    for (int r = 0; r < KERNEL; r++) begin
      row_ext = {CROW_W'(0), coef_rows[r]};
      for (int c = 0; c < KERNEL; c++) begin
        coef_tap[r*KERNEL + c] = row_ext[c*COEF_BITS +: COEF_BITS];
      end
    end
  end

  // Select the current tap
  assign coef_sel = coef_tap[tap_q];
  assign win_sel  = win_q[tap_q];

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      prod[ch] = PROD_W'(coef_sel) * PROD_W'($signed({1'b0, win_sel[ch*PIX_W +: PIX_W]}));
    end
  end

  // Accumulate one tap per cycle, kernel sum alongside
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else if (state_q == ST_READ) begin
      tap_q <= '0;
    end else if (state_q == ST_MAC) begin
      tap_q <= tap_q + TAP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      for (int ch = 0; ch < NCH; ch++) begin
        acc_q[ch] <= '0;
      end
      norm_q <= '0;
    end else if (state_q == ST_MAC) begin
      for (int ch = 0; ch < NCH; ch++) begin
        acc_q[ch] <= acc_q[ch] + ACC_W'(prod[ch]);
      end
      norm_q <= norm_q + NORM_W'(coef_sel);
    end
  end

  // --------------------------------------------------------------------------
  // Divider: magnitudes, one restoring step per cycle, sign applied at the end
  // --------------------------------------------------------------------------
  assign norm_abs = norm_q[NORM_W-1] ? NORM_W'(-norm_q) : NORM_W'(norm_q);

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      acc_abs[ch] = acc_q[ch][ACC_W-1] ? ACC_W'(-acc_q[ch]) : ACC_W'(acc_q[ch]);
      rem_sh[ch]  = {rem_q[ch], dq_q[ch][ACC_W-1]};
      trial[ch]   = {1'b0, rem_sh[ch]} - {2'b00, div_mag_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (state_q == ST_PREP) begin
      div_cnt_q <= '0;
    end else if (state_q == ST_DIV) begin
      div_cnt_q <= div_cnt_q + DCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PREP) begin
      div_mag_q <= (norm_q == '0) ? NORM_W'(1) : norm_abs;
      for (int ch = 0; ch < NCH; ch++) begin
        dq_q[ch]  <= acc_abs[ch];
        rem_q[ch] <= '0;
        neg_q[ch] <= acc_q[ch][ACC_W-1] ^ norm_q[NORM_W-1];
      end
    end else if (state_q == ST_DIV) begin
      for (int ch = 0; ch < NCH; ch++) begin
        if (!trial[ch][NORM_W+1]) begin
          rem_q[ch] <= trial[ch][NORM_W-1:0];
          dq_q[ch]  <= {dq_q[ch][ACC_W-2:0], 1'b1};
        end else begin
          rem_q[ch] <= rem_sh[ch][NORM_W-1:0];
          dq_q[ch]  <= {dq_q[ch][ACC_W-2:0], 1'b0};
        end
      end
    end
  end

  // Clamp quotient to 0..255
  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      if (neg_q[ch]) begin
        res[ch] = '0;
      end else if (dq_q[ch] > ACC_W'(PIX_MAX)) begin
        res[ch] = PIX_W'(PIX_MAX);
      end else begin
        res[ch] = dq_q[ch][PIX_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {res[2], res[1], res[0]};
      m_last_q <= fe_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

`ifndef SYNTHESIS
  // Every accepted pixel goes straight to the line memory update
  a_accept_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_READ)
    else $error("accepted pixel did not enter the read cycle");

  // A pending result is never overwritten
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && m_valid_q && !m_axis_tready) |=> state_q == ST_OUT)
    else $error("result loaded over an unconsumed result");

  // The divider never sees a zero divisor
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> div_mag_q != '0)
    else $error("zero divisor in divider");

  // Tap counter stays within the kernel while accumulating
  a_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MAC |-> tap_q < TAP_W'(KTAPS))
    else $error("tap counter out of range");
`endif

endmodule

/* tb/rkc_pixel_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkc_pixel_check: predicts and checks the filtered pixel stream
// Watches the register port and both stream channels. It keeps its own
// copy of the registers, line stores, window and counters, works out the
// filtered pixel that each accepted input pixel causes, and compares every
// output transaction field by field with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module rkc_pixel_check
  import rkc_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int COEF_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Register port
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic                  pready_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  // Pixel input channel
  input  logic                  in_tvalid_i,
  input  logic                  in_tready_i,
  input  logic [RGB_W-1:0]      in_tdata_i,   // pix_red, pix_green, pix_blue
  // Filtered output channel
  input  logic                  out_tvalid_i,
  input  logic                  out_tready_i,
  input  logic [RGB_W-1:0]      out_tdata_i,  // out_red, out_green, out_blue
  input  logic                  out_tlast_i,  // frame_end
  // Status toward the testbench top
  output int                    mismatches_o,
  output int                    pending_o
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  typedef struct {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_end;
  } filt_pix_t;

  filt_pix_t filtered_q[$];

  // Shadow registers
  logic [CFG_COEF_W-1:0]   coef_rows [KERNEL];
  logic [CFG_WIDTH_W-1:0]  width_reg;
  logic [CFG_HEIGHT_W-1:0] height_reg;

  // Shadow pixel state
  logic [RGB_W-1:0] older_line [MAX_WIDTH];
  logic [RGB_W-1:0] newer_line [MAX_WIDTH];
  logic [RGB_W-1:0] win [KERNEL][KERNEL];
  logic [COL_W-1:0] col_cnt;
  logic [ROW_W-1:0] row_cnt;

  // Advance the shadow state by one pixel; queue the filtered pixel if any
  task automatic predict_pixel(input logic [RGB_W-1:0] pix);
    int               w_eff;
    int               h_eff;
    int               col;
    int               norm;
    int               acc;
    int               kern [KERNEL][KERNEL];
    logic [RGB_W-1:0] top_px;
    logic [RGB_W-1:0] mid_px;
    logic             last_col;
    logic             last_row;
    logic [PIX_W-1:0] ch_res [NCH];
    filt_pix_t        exp_pix;
    w_eff = (width_reg < 3) ? 3 : (int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    h_eff = (height_reg < 3) ? 3 :
            (int'(height_reg) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    col      = int'(col_cnt) % MAX_WIDTH;
    top_px   = older_line[col];
    mid_px   = newer_line[col];
    last_col = int'(col_cnt) >= w_eff - 1;
    last_row = int'(row_cnt) >= h_eff - 1;

    // Shift the lines up and the window left
    older_line[col] = mid_px;
    newer_line[col] = pix;
    for (int r = 0; r < KERNEL; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top_px;
    win[1][2] = mid_px;
    win[2][2] = pix;

    // Filter the interior pixel whose window is now complete
    if (row_cnt >= 2 && col_cnt >= 2) begin
      norm = 0;
      for (int r = 0; r < KERNEL; r++) begin
        for (int c = 0; c < KERNEL; c++) begin
          kern[r][c] = int'($signed(coef_rows[r][c*COEF_BITS +: COEF_BITS]));
          norm += kern[r][c];
        end
      end
      if (norm == 0) norm = 1;
      for (int ch = 0; ch < NCH; ch++) begin
        acc = 0;
        for (int r = 0; r < KERNEL; r++) begin
          for (int c = 0; c < KERNEL; c++) begin
            acc += kern[r][c] * int'(win[r][c][ch*PIX_W +: PIX_W]);
          end
        end
        acc = acc / norm;
        if (acc > PIX_MAX) acc = PIX_MAX;
        if (acc < 0) acc = 0;
        ch_res[ch] = acc[PIX_W-1:0];
      end
      exp_pix.red       = ch_res[0];
      exp_pix.green     = ch_res[1];
      exp_pix.blue      = ch_res[2];
      exp_pix.frame_end = last_col && last_row;
      filtered_q.push_back(exp_pix);
    end

    // Step the raster position
    if (last_col) begin
      col_cnt = '0;
      row_cnt = last_row ? '0 : row_cnt + ROW_W'(1);
    end else begin
      col_cnt = col_cnt + COL_W'(1);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    filt_pix_t exp_pix;
    if (!rst_ni) begin
      coef_rows[0] = RST_COEF_TOP;
      coef_rows[1] = RST_COEF_MID;
      coef_rows[2] = RST_COEF_BOTTOM;
      width_reg    = RST_IMG_WIDTH;
      height_reg   = RST_IMG_HEIGHT;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        older_line[i] = '0;
        newer_line[i] = '0;
      end
      for (int r = 0; r < KERNEL; r++) begin
        for (int c = 0; c < KERNEL; c++) win[r][c] = '0;
      end
      col_cnt = '0;
      row_cnt = '0;
      filtered_q.delete();
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      // Track register writes
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[APB_ADDR_W-1:2])
          REG_COEF_TOP:    coef_rows[0] = pwdata_i[CFG_COEF_W-1:0];
          REG_COEF_MID:    coef_rows[1] = pwdata_i[CFG_COEF_W-1:0];
          REG_COEF_BOTTOM: coef_rows[2] = pwdata_i[CFG_COEF_W-1:0];
          REG_IMG_WIDTH:   width_reg    = pwdata_i[CFG_WIDTH_W-1:0];
          REG_IMG_HEIGHT:  height_reg   = pwdata_i[CFG_HEIGHT_W-1:0];
          default: ;
        endcase
      end

      // Compare the output transaction with the oldest prediction
      if (out_tvalid_i && out_tready_i) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected output pixel, actual rgb=%h last=%b",
                   $time, out_tdata_i, out_tlast_i);
          mismatches_o++;
        end else begin
          exp_pix = filtered_q.pop_front();
          if (out_tdata_i[0*PIX_W +: PIX_W] !== exp_pix.red   ||
              out_tdata_i[1*PIX_W +: PIX_W] !== exp_pix.green ||
              out_tdata_i[2*PIX_W +: PIX_W] !== exp_pix.blue  ||
              out_tlast_i !== exp_pix.frame_end) begin
            $display("%0t: pixel mismatch, expected r=%h g=%h b=%h last=%b",
                     $time, exp_pix.red, exp_pix.green, exp_pix.blue,
                     exp_pix.frame_end);
            $display("%0t:                 actual   r=%h g=%h b=%h last=%b",
                     $time, out_tdata_i[0*PIX_W +: PIX_W],
                     out_tdata_i[1*PIX_W +: PIX_W], out_tdata_i[2*PIX_W +: PIX_W],
                     out_tlast_i);
            mismatches_o++;
          end
        end
      end

      // Predict from the input transaction
      if (in_tvalid_i && in_tready_i) predict_pixel(in_tdata_i);

      pending_o = filtered_q.size();
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top of the RGB 3x3 convolution block
// Drives register writes and raster frames of pixels under random idling on
// both stream channels, holds off the output for a long stretch once, and
// gives the verdict from the mismatch and pending counts of the pixel checker.
// ----------------------------------------------------------------------------
module tb
  import rkc_pkg::*;
;

  localparam int MAX_WIDTH = 1024;
  localparam int COEF_BITS = 8;
  localparam int SETTLE_CYCLES = 64;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [RGB_W-1:0]      s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [RGB_W-1:0]      m_axis_tdata;
  logic                  m_axis_tlast;

  int mismatches;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold_cycles = 0;
  int frame_w;
  int frame_h;

  rgb_kernel_convolution_3x3 #(
    .MAX_WIDTH(MAX_WIDTH),
    .COEF_BITS(COEF_BITS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  rkc_pixel_check #(
    .MAX_WIDTH(MAX_WIDTH),
    .COEF_BITS(COEF_BITS)
  ) i_pixel_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .in_tvalid_i  (s_axis_tvalid),
    .in_tready_i  (s_axis_tready),
    .in_tdata_i   (s_axis_tdata),
    .out_tvalid_i (m_axis_tvalid),
    .out_tready_i (m_axis_tready),
    .out_tdata_i  (m_axis_tdata),
    .out_tlast_i  (m_axis_tlast),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("rgb_kernel_convolution_3x3 verification failed");
    $finish;
  end

  // Output consumer: random stalls, or a long hold when one is requested
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (recv_hold_cycles > 0) begin
        m_axis_tready = 1'b0;
        recv_hold_cycles--;
      end else begin
        m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Write one register: setup cycle, then access cycle until pready
  task automatic apb_write(input logic [REG_IDX_W-1:0] idx,
                           input logic [APB_DATA_W-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Hold until every predicted pixel has come out
  task automatic wait_drained();
    while (pending != 0) @(negedge clk_i);
  endtask

  // Let the block finish any border pixel before touching registers
  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [CFG_COEF_W-1:0] pack_row(input int left, input int center,
                                                     input int right);
    logic [CFG_COEF_W-1:0] row;
    row = '0;
    row[0*COEF_BITS +: COEF_BITS] = left[COEF_BITS-1:0];
    row[1*COEF_BITS +: COEF_BITS] = center[COEF_BITS-1:0];
    row[2*COEF_BITS +: COEF_BITS] = right[COEF_BITS-1:0];
    return row;
  endfunction

  task automatic set_kernel(input logic [CFG_COEF_W-1:0] top_row,
                            input logic [CFG_COEF_W-1:0] mid_row,
                            input logic [CFG_COEF_W-1:0] bot_row);
    wait_idle();
    apb_write(REG_COEF_TOP, APB_DATA_W'(top_row));
    apb_write(REG_COEF_MID, APB_DATA_W'(mid_row));
    apb_write(REG_COEF_BOTTOM, APB_DATA_W'(bot_row));
  endtask

  task automatic set_geometry(input int w, input int h);
    wait_idle();
    apb_write(REG_IMG_WIDTH, APB_DATA_W'(w));
    apb_write(REG_IMG_HEIGHT, APB_DATA_W'(h));
    frame_w = (w < 3) ? 3 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
    frame_h = (h < 3) ? 3 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
  endtask

  // Pick a kernel from a few families: raw, small positive, zero sum,
  // small signed and blur
  task automatic random_kernel();
    int kind;
    int k [KTAPS];
    int sum;
    kind = $urandom_range(4);
    sum  = 0;
    if (kind == 0) begin
      set_kernel(CFG_COEF_W'($urandom_range(24'hFFFFFF)),
                 CFG_COEF_W'($urandom_range(24'hFFFFFF)),
                 CFG_COEF_W'($urandom_range(24'hFFFFFF)));
    end else begin
      for (int i = 0; i < KTAPS; i++) begin
        case (kind)
          1:       k[i] = $urandom_range(4);
          2:       k[i] = int'($urandom_range(30)) - 15;
          3:       k[i] = int'($urandom_range(16)) - 8;
          default: k[i] = 1;
        endcase
        if (i != KTAPS / 2) sum += k[i];
      end
      if (kind == 2) k[KTAPS/2] = -sum;
      if (kind == 4) k[KTAPS/2] = $urandom_range(1, 8);
      set_kernel(pack_row(k[0], k[1], k[2]), pack_row(k[3], k[4], k[5]),
                 pack_row(k[6], k[7], k[8]));
    end
  endtask

  function automatic logic [PIX_W-1:0] pick_level(input bit extremes_only);
    case ($urandom_range(extremes_only ? 1 : 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(PIX_MAX));
    endcase
  endfunction

  // Offer one pixel with random gaps ahead of it
  task automatic send_pixel(input logic [RGB_W-1:0] rgb);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = rgb;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // Send a fixed number of pixels of random levels
  task automatic send_pixels(input int count);
    for (int i = 0; i < count; i++) begin
      send_pixel({pick_level(1'b0), pick_level(1'b0), pick_level(1'b0)});
    end
  endtask

  // Send one whole frame; optionally pause halfway until drained
  task automatic run_frame(input bit extremes_only, input bit pause_mid);
    int total;
    total = frame_w * frame_h;
    for (int i = 0; i < total; i++) begin
      send_pixel({pick_level(extremes_only), pick_level(extremes_only),
                  pick_level(extremes_only)});
      if (pause_mid && i == total / 2) wait_drained();
    end
  endtask

  initial begin
    int phase_items;
    bit first;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: undersized geometry, identity, zero-sum and negative-sum
    // kernels at the coefficient extremes, pixels at 0 and 255
    send_idle_pct = 35;
    recv_idle_pct = 63;
    set_geometry(0, 2);
    set_kernel(pack_row(0, 0, 0), pack_row(0, 1, 0), pack_row(0, 0, 0));
    run_frame(1'b1, 1'b0);
    set_kernel(pack_row(-1, -1, -1), pack_row(-1, 8, -1), pack_row(-1, -1, -1));
    run_frame(1'b1, 1'b0);
    set_geometry(1, 3);
    set_kernel(pack_row(-128, -128, -128), pack_row(-128, 127, -128),
               pack_row(127, 127, 127));
    run_frame(1'b1, 1'b0);

    // Random frames in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 63 : 0;
      recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 35 : 0;
      if (phase == 2) begin
        // Oversized width: start the first line, then shrink the width to 8 pixels
        random_kernel();
        set_geometry(2047, 3);
        send_pixels(8);
        set_geometry(8, 3);
        send_pixels(17);
        // Oversized height: five lines, then end the frame after six lines
        random_kernel();
        set_geometry(4, 8191);
        send_pixels(20);
        set_geometry(4, 6);
        send_pixels(4);
      end
      phase_items = 0;
      first       = 1'b1;
      while (phase_items < 150) begin
        random_kernel();
        if (first && phase == 0) begin
          // Back up the output so the block stalls its input
          set_geometry(10, 6);
          @(posedge clk_i);
          recv_hold_cycles = 500;
          @(negedge clk_i);
        end else begin
          set_geometry($urandom_range(10), $urandom_range(8));
        end
        run_frame(1'b0, first && phase == 1);
        phase_items += frame_w * frame_h;
        first = 1'b0;
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("rgb_kernel_convolution_3x3 verification clean");
    end else begin
      $display("rgb_kernel_convolution_3x3 verification failed");
    end
    $finish;
  end

endmodule
